/* hdl/websocket_frame_decoder_assert.svh */
// Assertion macros used by the checker file.
`ifndef WEBSOCKET_FRAME_DECODER_ASSERT_SVH
`define WEBSOCKET_FRAME_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSFD_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("websocket frame decoder check failed");

// The consequent must hold in the cycle after the antecedent.
`define WSFD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("websocket frame decoder check failed");

`endif

/* hdl/wsfd_pkg.sv */
package wsfd_pkg;

    localparam int unsigned LEN_W = 64;

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;
    localparam logic [3:0] EXT16_BYTES = 4'd2;
    localparam logic [3:0] EXT64_BYTES = 4'd8;
    localparam logic [2:0] MASK_KEY_BYTES = 3'd4;
    localparam logic [LEN_W-1:0] MAX_LEN_RESET = 64'd268435456;

    localparam logic [3:0] OP_CONT = 4'h0;
    localparam logic [3:0] OP_TEXT = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE = 4'h8;
    localparam logic [3:0] OP_PING = 4'h9;
    localparam logic [3:0] OP_PONG = 4'hA;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ERR_RSV       = 2'd0,
        ERR_OPCODE    = 2'd1,
        ERR_TOO_LARGE = 2'd2
    } err_code_t;

    typedef enum logic [4:0] {
        PH_BYTE0   = 5'b00001,
        PH_BYTE1   = 5'b00010,
        PH_EXTLEN  = 5'b00100,
        PH_MASK    = 5'b01000,
        PH_PAYLOAD = 5'b10000
    } phase_t;

    typedef struct packed {
        kind_t            kind;
        logic             fin;
        logic [3:0]       opcode;
        logic [LEN_W-1:0] payload_length;
        logic [7:0]       payload_byte;
        logic             last;
        err_code_t        error_code;
    } result_t;

    function automatic logic opcode_known(input logic [3:0] op);
        return (op == OP_CONT) || (op == OP_TEXT) || (op == OP_BINARY) ||
               (op == OP_CLOSE) || (op == OP_PING) || (op == OP_PONG);
    endfunction

endpackage

/* hdl/websocket_frame_decoder.sv */
// Result words are registered; one that meets a stalled result register waits in the skid entry.
// Throughput: one stream byte per cycle while s_ready is high, set by the single registered decode step.
// A two-entry output stage (result register plus skid) keeps s_ready high while one
// result waits; s_ready drops only when both entries are full.
// Reset (aresetn low, synchronous) returns to the first header byte, clears the
// halt after an error, empties the output stage and restores the length limit.
module websocket_frame_decoder
    import wsfd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_max_payload_length,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [7:0]       s_stream_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_kind,
    output logic             m_fin,
    output logic [3:0]       m_opcode,
    output logic [LEN_W-1:0] m_payload_length,
    output logic [7:0]       m_payload_byte,
    output logic             m_last,
    output logic [1:0]       m_error_code
);

    logic [LEN_W-1:0] max_len_reg;
    phase_t           phase_reg, phase_next;
    logic             halted_reg, halted_next;
    logic             fin_reg, fin_next;
    logic [3:0]       opcode_reg, opcode_next;
    logic             masked_reg, masked_next;
    logic [3:0]       ext_left_reg, ext_left_next;
    logic [LEN_W-1:0] len_acc_reg, len_acc_next;
    logic [31:0]      key_reg, key_next;
    logic [2:0]       key_left_reg, key_left_next;
    logic [LEN_W-1:0] remaining_reg, remaining_next;
    logic [1:0]       mask_idx_reg, mask_idx_next;

    logic             out_valid_reg, out_valid_next;
    result_t          out_reg, out_next;
    logic             skid_valid_reg, skid_valid_next;
    result_t          skid_reg, skid_next;

    logic             accept;
    logic             produce;
    result_t          res;
    logic             len_check;
    logic             do_header;
    logic [LEN_W-1:0] len_val;
    logic [LEN_W-1:0] hdr_len;
    logic [LEN_W-1:0] shifted_len;
    logic [7:0]       key_byte;

    assign cfg_ready = 1'b1;
    assign s_ready   = !skid_valid_reg;
    assign accept    = s_valid && s_ready;

    assign shifted_len = {len_acc_reg[LEN_W-9:0], s_stream_byte};

    always_comb begin
        case (mask_idx_reg)
            2'd0:    key_byte = key_reg[31:24];
            2'd1:    key_byte = key_reg[23:16];
            2'd2:    key_byte = key_reg[15:8];
            default: key_byte = key_reg[7:0];
        endcase
    end

    always_comb begin
        phase_next     = phase_reg;
        halted_next    = halted_reg;
        fin_next       = fin_reg;
        opcode_next    = opcode_reg;
        masked_next    = masked_reg;
        ext_left_next  = ext_left_reg;
        len_acc_next   = len_acc_reg;
        key_next       = key_reg;
        key_left_next  = key_left_reg;
        remaining_next = remaining_reg;
        mask_idx_next  = mask_idx_reg;
        produce        = 1'b0;
        res            = '0;
        len_check      = 1'b0;
        do_header      = 1'b0;
        len_val        = len_acc_reg;
        hdr_len        = len_acc_reg;

        if (accept && !halted_reg) begin
            case (phase_reg)
                PH_BYTE0: begin
                    if (s_stream_byte[6:4] != 3'd0) begin
                        produce        = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_RSV;
                        halted_next    = 1'b1;
                    end else if (!opcode_known(s_stream_byte[3:0])) begin
                        produce        = 1'b1;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_OPCODE;
                        halted_next    = 1'b1;
                    end else begin
                        fin_next    = s_stream_byte[7];
                        opcode_next = s_stream_byte[3:0];
                        phase_next  = PH_BYTE1;
                    end
                end
                PH_BYTE1: begin
                    masked_next  = s_stream_byte[7];
                    len_acc_next = '0;
                    if (s_stream_byte[6:0] == LEN7_EXT16) begin
                        ext_left_next = EXT16_BYTES;
                        phase_next    = PH_EXTLEN;
                    end else if (s_stream_byte[6:0] == LEN7_EXT64) begin
                        ext_left_next = EXT64_BYTES;
                        phase_next    = PH_EXTLEN;
                    end else begin
                        len_val   = {{(LEN_W-7){1'b0}}, s_stream_byte[6:0]};
                        len_check = 1'b1;
                    end
                end
                PH_EXTLEN: begin
                    len_acc_next  = shifted_len;
                    ext_left_next = ext_left_reg - 4'd1;
                    if (ext_left_reg == 4'd1) begin
                        len_val   = shifted_len;
                        len_check = 1'b1;
                    end
                end
                PH_MASK: begin
                    key_next      = {key_reg[23:0], s_stream_byte};
                    key_left_next = key_left_reg - 3'd1;
                    if (key_left_reg == 3'd1) begin
                        hdr_len   = len_acc_reg;
                        do_header = 1'b1;
                    end
                end
                PH_PAYLOAD: begin
                    produce          = 1'b1;
                    res.kind         = KIND_PAYLOAD;
                    res.fin          = fin_reg;
                    res.opcode       = opcode_reg;
                    res.payload_byte = masked_reg ? (s_stream_byte ^ key_byte) : s_stream_byte;
                    mask_idx_next    = mask_idx_reg + 2'd1;
                    remaining_next   = remaining_reg - {{(LEN_W-1){1'b0}}, 1'b1};
                    if (remaining_reg == {{(LEN_W-1){1'b0}}, 1'b1}) begin
                        res.last   = 1'b1;
                        phase_next = PH_BYTE0;
                    end
                end
                default: begin
                    phase_next = PH_BYTE0;
                end
            endcase
        end

        if (len_check) begin
            len_acc_next = len_val;
            key_next     = '0;
            if (len_val > max_len_reg) begin
                produce        = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_TOO_LARGE;
                halted_next    = 1'b1;
            end else if (masked_next) begin
                key_left_next = MASK_KEY_BYTES;
                phase_next    = PH_MASK;
            end else begin
                hdr_len   = len_val;
                do_header = 1'b1;
            end
        end

        if (do_header) begin
            produce            = 1'b1;
            res.kind           = KIND_HEADER;
            res.fin            = fin_reg;
            res.opcode         = opcode_reg;
            res.payload_length = hdr_len;
            remaining_next     = hdr_len;
            mask_idx_next      = 2'd0;
            if (hdr_len == '0) begin
                res.last   = 1'b1;
                phase_next = PH_BYTE0;
            end else begin
                phase_next = PH_PAYLOAD;
            end
        end
    end

    // The result register drains from the skid entry first; the skid entry only
    // fills while the result register is stalled.
    always_comb begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;
        if (!out_valid_reg || m_ready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = produce;
                out_next       = res;
            end
        end else if (produce) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg    <= MAX_LEN_RESET;
            phase_reg      <= PH_BYTE0;
            halted_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                max_len_reg <= cfg_max_payload_length;
            end
            phase_reg      <= phase_next;
            halted_reg     <= halted_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        fin_reg       <= fin_next;
        opcode_reg    <= opcode_next;
        masked_reg    <= masked_next;
        ext_left_reg  <= ext_left_next;
        len_acc_reg   <= len_acc_next;
        key_reg       <= key_next;
        key_left_reg  <= key_left_next;
        remaining_reg <= remaining_next;
        mask_idx_reg  <= mask_idx_next;
        out_reg       <= out_next;
        skid_reg      <= skid_next;
    end

    assign m_valid          = out_valid_reg;
    assign m_kind           = out_reg.kind;
    assign m_fin            = out_reg.fin;
    assign m_opcode         = out_reg.opcode;
    assign m_payload_length = out_reg.payload_length;
    assign m_payload_byte   = out_reg.payload_byte;
    assign m_last           = out_reg.last;
    assign m_error_code     = out_reg.error_code;

endmodule

/* hdl/wsfd_checker.sv */
`include "websocket_frame_decoder_assert.svh"

module wsfd_checker
    import wsfd_pkg::*;
(
    input logic             aclk,
    input logic             aresetn,
    input logic             m_valid,
    input logic             m_ready,
    input logic [1:0]       m_kind,
    input logic             m_fin,
    input logic [3:0]       m_opcode,
    input logic [LEN_W-1:0] m_payload_length,
    input logic [7:0]       m_payload_byte,
    input logic             m_last,
    input logic [1:0]       m_error_code
);

    logic err_seen_reg, err_seen_next;

    // Once an error word has been taken, the decoder stays silent until reset.
    assign err_seen_next = err_seen_reg || (m_valid && m_ready && (m_kind == KIND_ERROR));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            err_seen_reg <= 1'b0;
        end else begin
            err_seen_reg <= err_seen_next;
        end
    end

    `WSFD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_kind) && $stable(m_payload_length) && $stable(m_payload_byte) && $stable(m_last))
    `WSFD_ASSERT_SAME(a_silent_after_error, aclk, aresetn, err_seen_reg, !m_valid)
    `WSFD_ASSERT_SAME(a_error_fields, aclk, aresetn, m_valid && (m_kind == KIND_ERROR), !m_last && !m_fin && (m_opcode == 4'd0) && (m_payload_length == '0) && (m_error_code != 2'd3))
    `WSFD_ASSERT_SAME(a_header_last, aclk, aresetn, m_valid && (m_kind == KIND_HEADER), (m_last == (m_payload_length == '0)) && (m_payload_byte == 8'd0) && (m_error_code == ERR_RSV))
    `WSFD_ASSERT_SAME(a_kind_legal, aclk, aresetn, m_valid, (m_kind == KIND_HEADER) || (m_kind == KIND_PAYLOAD) || (m_kind == KIND_ERROR))

endmodule

bind websocket_frame_decoder wsfd_checker u_wsfd_checker (.*);

/* tb/sv/websocket_frame_decoder_tb.sv */
`timescale 1ns / 1ps

module websocket_frame_decoder_tb;
    import wsfd_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;
    localparam int HOLD_AFTER = 200;
    localparam int NUM_DIRECTED = 28;
    localparam result_t NO_WORD = '0;
    localparam logic [3:0] KNOWN_OPS [6] = '{OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING,
                                             OP_PONG};

    typedef struct {
        logic [7:0] data;
        bit         typed;
        result_t    want;
    } stim_row_t;

    typedef enum int {
        TAIL_RSV,
        TAIL_OPCODE,
        TAIL_HUGE_REJECT,
        TAIL_SHORT_REJECT,
        TAIL_HUGE_ACCEPT
    } tail_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [LEN_W-1:0] cfg_max_payload_length = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [7:0]       s_stream_byte = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [1:0]       m_kind;
    logic             m_fin;
    logic [3:0]       m_opcode;
    logic [LEN_W-1:0] m_payload_length;
    logic [7:0]       m_payload_byte;
    logic             m_last;
    logic [1:0]       m_error_code;

    // Decoder state as the stream has moved it so far.
    phase_t           st_phase = PH_BYTE0;
    logic             st_fin = 1'b0;
    logic [3:0]       st_opcode = '0;
    logic             st_masked = 1'b0;
    logic [3:0]       st_ext_left = '0;
    logic [LEN_W-1:0] st_len = '0;
    logic [31:0]      st_key = '0;
    logic [2:0]       st_key_left = '0;
    logic [LEN_W-1:0] st_remaining = '0;
    logic [1:0]       st_key_idx = '0;
    logic             st_halted = 1'b0;
    logic [LEN_W-1:0] lim_max_len = MAX_LEN_RESET;

    result_t     pending_results[$];
    stim_row_t   directed_rows[NUM_DIRECTED];
    int          bytes_sent = 0;
    int          results_seen = 0;
    int          mismatch_count = 0;
    int          quiet_cycles = 0;
    int unsigned cycle_count = 0;
    int          hold_left = 0;
    bit          hold_done = 1'b0;

    websocket_frame_decoder dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_max_payload_length (cfg_max_payload_length),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_stream_byte          (s_stream_byte),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_kind                 (m_kind),
        .m_fin                  (m_fin),
        .m_opcode               (m_opcode),
        .m_payload_length       (m_payload_length),
        .m_payload_byte         (m_payload_byte),
        .m_last                 (m_last),
        .m_error_code           (m_error_code)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Both sides run without gaps for one stretch of the run.
    function automatic bit idle_now();
        return !(cycle_count >= 600 && cycle_count < 1100) && ($urandom_range(0, 99) < 14);
    endfunction

    function automatic result_t header_word(logic fin, logic [3:0] op, logic [LEN_W-1:0] len,
                                            logic last);
        result_t w;
        w = '0;
        w.kind = KIND_HEADER;
        w.fin = fin;
        w.opcode = op;
        w.payload_length = len;
        w.last = last;
        return w;
    endfunction

    function automatic result_t payload_word(logic fin, logic [3:0] op, logic [7:0] data,
                                             logic last);
        result_t w;
        w = '0;
        w.kind = KIND_PAYLOAD;
        w.fin = fin;
        w.opcode = op;
        w.payload_byte = data;
        w.last = last;
        return w;
    endfunction

    task automatic add_expected(input result_t w);
        pending_results.insert(pending_results.size(), w);
    endtask

    task automatic halt_with(input err_code_t code, output bit got, output result_t r);
        r = '0;
        r.kind = KIND_ERROR;
        r.error_code = code;
        got = 1'b1;
        st_halted = 1'b1;
    endtask

    task automatic open_payload(output bit got, output result_t r);
        r = header_word(st_fin, st_opcode, st_len, st_len == 0);
        got = 1'b1;
        st_remaining = st_len;
        st_key_idx = '0;
        st_phase = (st_len == 0) ? PH_BYTE0 : PH_PAYLOAD;
    endtask

    task automatic close_length(output bit got, output result_t r);
        got = 1'b0;
        r = '0;
        if (st_len > lim_max_len) begin
            halt_with(ERR_TOO_LARGE, got, r);
        end else if (st_masked) begin
            st_key = '0;
            st_key_left = MASK_KEY_BYTES;
            st_phase = PH_MASK;
        end else begin
            st_key = '0;
            open_payload(got, r);
        end
    endtask

    task automatic decode_byte(input logic [7:0] b, output bit got, output result_t r);
        logic [7:0] key_byte;
        got = 1'b0;
        r = '0;
        if (!st_halted) begin
            case (st_phase)
                PH_BYTE0: begin
                    if (b[6:4] != 3'b000) begin
                        halt_with(ERR_RSV, got, r);
                    end else if (!(b[3:0] inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE,
                                                  OP_PING, OP_PONG})) begin
                        halt_with(ERR_OPCODE, got, r);
                    end else begin
                        st_fin = b[7];
                        st_opcode = b[3:0];
                        st_phase = PH_BYTE1;
                    end
                end
                PH_BYTE1: begin
                    st_masked = b[7];
                    st_len = '0;
                    if (b[6:0] == LEN7_EXT16) begin
                        st_ext_left = EXT16_BYTES;
                        st_phase = PH_EXTLEN;
                    end else if (b[6:0] == LEN7_EXT64) begin
                        st_ext_left = EXT64_BYTES;
                        st_phase = PH_EXTLEN;
                    end else begin
                        st_len = 64'(b[6:0]);
                        close_length(got, r);
                    end
                end
                PH_EXTLEN: begin
                    st_len = {st_len[LEN_W-9:0], b};
                    st_ext_left = st_ext_left - 1'b1;
                    if (st_ext_left == 0) begin
                        close_length(got, r);
                    end
                end
                PH_MASK: begin
                    st_key = {st_key[23:0], b};
                    st_key_left = st_key_left - 1'b1;
                    if (st_key_left == 0) begin
                        open_payload(got, r);
                    end
                end
                PH_PAYLOAD: begin
                    key_byte = st_masked ? st_key[8 * (3 - st_key_idx) +: 8] : 8'h00;
                    st_remaining = st_remaining - 1'b1;
                    r = payload_word(st_fin, st_opcode, b ^ key_byte, st_remaining == 0);
                    got = 1'b1;
                    st_key_idx = st_key_idx + 1'b1;
                    if (st_remaining == 0) begin
                        st_phase = PH_BYTE0;
                    end
                end
                default: begin
                    st_phase = PH_BYTE0;
                end
            endcase
        end
    endtask

    task automatic send_byte(input logic [7:0] b);
        while (idle_now()) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_stream_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic feed(input logic [7:0] b);
        bit got;
        result_t r;
        send_byte(b);
        decode_byte(b, got, r);
        if (got) begin
            add_expected(r);
        end
        bytes_sent++;
    endtask

    task automatic write_max_length(input logic [LEN_W-1:0] value);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_max_payload_length <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        lim_max_len = value;
    endtask

    // Sends one well-formed frame whose length stays within the limit.
    task automatic send_random_frame(input logic [LEN_W-1:0] limit);
        int unsigned n;
        int unsigned pick;
        logic [3:0] op;
        logic fin;
        logic masked;
        logic [LEN_W-1:0] len;
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
            n = $urandom_range(0, 16);
        end else if (pick < 90) begin
            n = $urandom_range(17, 130);
        end else begin
            n = $urandom_range(131, 300);
        end
        if (limit < 64'(n)) begin
            n = $urandom_range(0, 32'(limit));
        end
        len = 64'(n);
        op = KNOWN_OPS[3'($urandom_range(0, 5))];
        fin = 1'($urandom);
        masked = 1'($urandom);
        feed({fin, 3'b000, op});
        pick = $urandom_range(0, 9);
        if (n <= 125 && pick < 7) begin
            feed({masked, len[6:0]});
        end else if (pick < 9) begin
            feed({masked, LEN7_EXT16});
            feed(len[15:8]);
            feed(len[7:0]);
        end else begin
            feed({masked, LEN7_EXT64});
            for (int i = 7; i >= 0; i--) feed(len[8*i +: 8]);
        end
        if (masked) begin
            repeat (4) feed(8'($urandom));
        end
        repeat (n) feed(8'($urandom));
    endtask

    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else if (!hold_done && results_seen >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !idle_now();
        end
    end

    always @(posedge aclk) begin : check_words
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            results_seen <= results_seen + 1;
            if (pending_results.size() == 0) begin
                if (mismatch_count < 10) begin
                    $display("unexpected result word: kind %0d fin %0b opcode %0h length %0h",
                             m_kind, m_fin, m_opcode, m_payload_length);
                end
                mismatch_count = mismatch_count + 1;
            end else begin
                want = pending_results.pop_front();
                if (m_kind !== want.kind || m_fin !== want.fin || m_opcode !== want.opcode ||
                    m_payload_length !== want.payload_length ||
                    m_payload_byte !== want.payload_byte || m_last !== want.last ||
                    m_error_code !== want.error_code) begin
                    if (mismatch_count < 10) begin
                        $display("mismatch on result word %0d", results_seen);
                        $display("  expected kind %0d fin %0b opcode %0h length %0h byte %0h last %0b error %0d",
                                 want.kind, want.fin, want.opcode, want.payload_length,
                                 want.payload_byte, want.last, want.error_code);
                        $display("  actual   kind %0d fin %0b opcode %0h length %0h byte %0h last %0b error %0d",
                                 m_kind, m_fin, m_opcode, m_payload_length, m_payload_byte,
                                 m_last, m_error_code);
                    end
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        logic [LEN_W-1:0] big;
        logic [3:0] op;
        bit got;
        result_t r;
        int goal;
        tail_t tail_kind;

        directed_rows = '{
            '{8'h8A, 1'b0, NO_WORD},
            '{8'h00, 1'b1, header_word(1'b1, OP_PONG, 64'd0, 1'b1)},
            '{8'h02, 1'b0, NO_WORD},
            '{8'h00, 1'b1, header_word(1'b0, OP_BINARY, 64'd0, 1'b1)},
            '{8'h88, 1'b0, NO_WORD},
            '{8'h00, 1'b1, header_word(1'b1, OP_CLOSE, 64'd0, 1'b1)},
            '{8'h01, 1'b0, NO_WORD},
            '{8'h7E, 1'b0, NO_WORD},
            '{8'h00, 1'b0, NO_WORD},
            '{8'h01, 1'b1, header_word(1'b0, OP_TEXT, 64'd1, 1'b0)},
            '{8'hFF, 1'b1, payload_word(1'b0, OP_TEXT, 8'hFF, 1'b1)},
            '{8'h80, 1'b0, NO_WORD},
            '{8'h7F, 1'b0, NO_WORD},
            '{8'h00, 1'b0, NO_WORD},
            '{8'h00, 1'b0, NO_WORD},
            '{8'h00, 1'b0, NO_WORD},
            '{8'h00, 1'b0, NO_WORD},
            '{8'h00, 1'b0, NO_WORD},
            '{8'h00, 1'b0, NO_WORD},
            '{8'h00, 1'b0, NO_WORD},
            '{8'h00, 1'b1, header_word(1'b1, OP_CONT, 64'd0, 1'b1)},
            '{8'h89, 1'b0, NO_WORD},
            '{8'h81, 1'b0, NO_WORD},
            '{8'hFF, 1'b0, NO_WORD},
            '{8'h00, 1'b0, NO_WORD},
            '{8'h00, 1'b0, NO_WORD},
            '{8'h00, 1'b1, header_word(1'b1, OP_PING, 64'd1, 1'b0)},
            '{8'h0F, 1'b1, payload_word(1'b1, OP_PING, 8'hF0, 1'b1)}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[i]) begin
            send_byte(directed_rows[i].data);
            decode_byte(directed_rows[i].data, got, r);
            if (directed_rows[i].typed) begin
                add_expected(directed_rows[i].want);
            end else if (got) begin
                add_expected(r);
            end
            bytes_sent++;
        end

        // With a zero limit only empty frames get through.
        write_max_length('0);
        while (bytes_sent < 180) send_random_frame(lim_max_len);

        write_max_length('1);
        while (bytes_sent < 780) send_random_frame(lim_max_len);

        repeat (3) begin
            write_max_length(64'($urandom_range(1, 300)));
            goal = bytes_sent + 230;
            while (bytes_sent < goal) send_random_frame(lim_max_len);
        end

        // The run ends on one protocol error or on a frame too long to finish.
        tail_kind = tail_t'($urandom_range(0, 4));
        case (tail_kind)
            TAIL_RSV: begin
                feed({1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
            end
            TAIL_OPCODE: begin
                do begin
                    op = 4'($urandom);
                end while (op inside {OP_CONT, OP_TEXT, OP_BINARY, OP_CLOSE, OP_PING, OP_PONG});
                feed({1'($urandom), 3'b000, op});
            end
            TAIL_HUGE_REJECT: begin
                write_max_length({1'b0, 31'($urandom), 32'($urandom)});
                feed({1'b1, 3'b000, OP_BINARY});
                feed({1'($urandom), LEN7_EXT64});
                big = {1'b1, 31'($urandom), 32'($urandom)};
                for (int i = 7; i >= 0; i--) feed(big[8*i +: 8]);
            end
            TAIL_SHORT_REJECT: begin
                write_max_length(64'($urandom_range(0, 124)));
                feed({1'b1, 3'b000, KNOWN_OPS[3'($urandom_range(0, 5))]});
                feed({1'($urandom), 7'(lim_max_len + 1)});
            end
            default: begin
                write_max_length('1);
                feed({1'($urandom), 3'b000, KNOWN_OPS[3'($urandom_range(0, 5))]});
                feed({1'b1, LEN7_EXT64});
                big = $urandom_range(0, 1) ? '1 : {1'b1, 31'($urandom), 32'($urandom)};
                for (int i = 7; i >= 0; i--) feed(big[8*i +: 8]);
                repeat (4) feed(8'($urandom));
            end
        endcase
        repeat (40) feed(8'($urandom));
        s_valid <= 1'b0;

        while (pending_results.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+hdl
hdl/wsfd_pkg.sv
hdl/websocket_frame_decoder.sv
hdl/wsfd_checker.sv
tb/sv/websocket_frame_decoder_tb.sv
